>>> rtl/edb_pkg.sv
package edb_pkg;

    // line buffer geometry
    localparam int MAX_WIDTH  = 1024;
    localparam int MIN_WIDTH  = 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int LW_W       = 11;
    localparam int CMP_W      = (WID_W > LW_W) ? WID_W : LW_W;
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // pixel and configuration widths
    localparam int PIX_W = 8;
    localparam int THR_W = 8;
    localparam int CFG_W = 11;

    localparam logic [THR_W-1:0] THRESHOLD_RESET  = 8'd127;
    localparam logic [LW_W-1:0]  LINE_WIDTH_RESET = 11'd1024;
    localparam logic [PIX_W-1:0] WHITE            = 8'd255;
    localparam logic [PIX_W-1:0] BLACK            = 8'd0;

    typedef enum logic [0:0] {
        REG_THRESHOLD  = 1'b0,
        REG_LINE_WIDTH = 1'b1
    } cfg_index_t;

    // shares owed to one column of the next row
    typedef struct packed {
        logic signed [5:0] dr;
        logic signed [7:0] d;
        logic signed [6:0] dl;
    } share_t;

    localparam int SHARE_W = $bits(share_t);

    // one pixel on its way from the input to the diffusion stage
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             fs;
        logic             first_row;
        logic             last;
        logic [COL_W-1:0] col;
    } item_t;

    // up to two line buffer writes per pixel, at col-1 and at col
    typedef struct packed {
        logic             a_en;
        logic [COL_W-1:0] a_col;
        share_t           a_data;
        logic             b_en;
        logic [COL_W-1:0] b_col;
        share_t           b_data;
    } wr_t;

    function automatic logic [PIX_W-1:0] clamp_add(input logic [PIX_W-1:0] v,
                                                    input logic signed [7:0] s);
        logic signed [9:0] sum;
        sum = $signed({2'b00, v}) + 10'(s);
        if (sum < 10'sd0)
            return BLACK;
        else if (sum > 10'sd255)
            return WHITE;
        else
            return sum[PIX_W-1:0];
    endfunction

    // ceil(n / 16) for signed n, via floor((n + 15) / 16)
    function automatic logic signed [7:0] ceil16(input logic signed [12:0] n);
        logic signed [12:0] t;
        t = n + 13'sd15;
        return 8'(t >>> 4);
    endfunction

endpackage

>>> rtl/edb_ram.sv
module edb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> rtl/edb_diffuse.sv
module edb_diffuse (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  edb_pkg::item_t           item,
    input  edb_pkg::share_t          above,
    input  logic [edb_pkg::THR_W-1:0] threshold,
    output logic [edb_pkg::PIX_W-1:0] result,
    output edb_pkg::wr_t             wr
);
    import edb_pkg::*;

    logic signed [7:0] right_share_reg;
    logic signed [5:0] held_dr_reg;
    logic signed [7:0] held_d_reg;
    logic signed [5:0] older_dr_reg;

    logic signed [7:0] r_in;
    logic signed [5:0] held_dr_in;
    logic signed [7:0] held_d_in;
    logic signed [5:0] older_dr_in;

    logic [PIX_W-1:0]   v1, v2, v3, v4;
    logic signed [8:0]  err;
    logic signed [12:0] err_w;
    logic signed [7:0]  r_share;
    logic signed [7:0]  d_share;
    logic signed [6:0]  dl_share;
    logic signed [5:0]  dr_share;

    // frame start drops whatever the previous frame left in the row registers
    assign r_in        = item.fs ? 8'sd0 : right_share_reg;
    assign held_dr_in  = item.fs ? 6'sd0 : held_dr_reg;
    assign held_d_in   = item.fs ? 8'sd0 : held_d_reg;
    assign older_dr_in = item.fs ? 6'sd0 : older_dr_reg;

    always_comb
    begin
        if (item.first_row)
        begin
            v3 = item.pixel;
            v1 = item.pixel;
            v2 = item.pixel;
        end
        else
        begin
            v1 = clamp_add(item.pixel, 8'(above.dr));
            v2 = clamp_add(v1, above.d);
            v3 = clamp_add(v2, 8'(above.dl));
        end
        v4 = clamp_add(v3, r_in);
    end

    assign result = (v4 > threshold) ? WHITE : BLACK;

    assign err      = $signed({1'b0, v4}) - $signed({1'b0, result});
    assign err_w    = 13'(err);
    assign r_share  = ceil16(err_w * 13'sd7);
    assign dl_share = 7'(ceil16(err_w * 13'sd3));
    assign d_share  = ceil16(err_w * 13'sd5);
    assign dr_share = 6'(ceil16(err_w));

    always_comb
    begin
        wr.a_en      = advance && (item.col != '0);
        wr.a_col     = item.col - 1'b1;
        wr.a_data.dr = older_dr_in;
        wr.a_data.d  = held_d_in;
        wr.a_data.dl = dl_share;
        wr.b_en      = advance && item.last;
        wr.b_col     = item.col;
        wr.b_data.dr = held_dr_in;
        wr.b_data.d  = d_share;
        wr.b_data.dl = 7'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_share_reg <= '0;
            held_dr_reg     <= '0;
            held_d_reg      <= '0;
            older_dr_reg    <= '0;
        end
        else if (advance)
        begin
            if (item.last)
            begin
                right_share_reg <= '0;
                held_dr_reg     <= '0;
                held_d_reg      <= '0;
                older_dr_reg    <= '0;
            end
            else
            begin
                right_share_reg <= r_share;
                held_dr_reg     <= dr_share;
                held_d_reg      <= d_share;
                older_dr_reg    <= held_dr_in;
            end
        end
    end

endmodule

>>> rtl/error_diffusion_binarizer.sv
// Floyd-Steinberg error diffusion of a gray pixel stream in raster order. Each
// accepted pixel gets the shares owed by its neighbors above and to the left,
// is compared against threshold and comes out as 0 or 255 with row_end on the
// last pixel of each row; frame_start restarts the row and column tracking.
// Rate is one pixel per clock while the output is taken, set by the right-share
// loop (four clamped adds, the compare and the share multiplies) inside the
// diffusion stage; each pixel passes the line buffer read, then the output
// register, which holds its result until it is taken. The shares for the
// next row sit in a line buffer split into even and odd column banks, so the
// two writes at the end of a row land in different banks; a read that meets a
// write to the same column in the same cycle is forwarded. The buffer has no
// clearing pass after reset. Write threshold and line_width only while no
// pixel is in flight.
module error_diffusion_binarizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [edb_pkg::PIX_W-1:0]     pixel_in,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [edb_pkg::PIX_W-1:0]     out_value,
    output logic                          row_end,
    input  logic                          cfg_we,
    input  edb_pkg::cfg_index_t           cfg_index,
    input  logic [edb_pkg::CFG_W-1:0]     cfg_data
);
    import edb_pkg::*;

    // configuration
    logic [THR_W-1:0] threshold_reg;
    logic [LW_W-1:0]  line_width_reg;

    // row tracking at the input side
    logic [COL_W-1:0] col_reg;
    logic             first_row_reg;

    // pixel waiting for its line buffer word
    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic             fwd_hit_reg;
    share_t           fwd_data_reg;

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_value_reg;
    logic             row_end_reg;

    logic             advance;
    logic             accept;
    item_t            new_item;
    logic [CMP_W-1:0] lw_ext;
    logic [CMP_W-1:0] w_eff;
    share_t           above;
    logic [PIX_W-1:0] result;
    wr_t              wr;
    logic             hit_a;
    logic             hit_b;

    logic               bank_we    [2];
    logic [BANK_AW-1:0] bank_waddr [2];
    logic [SHARE_W-1:0] bank_wdata [2];
    logic [SHARE_W-1:0] bank_rdata [2];
    logic [BANK_AW-1:0] bank_raddr;

    // the diffusion stage moves whenever it holds a pixel and the output register has room
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // effective width, held to MIN_WIDTH..MAX_WIDTH
    assign lw_ext = CMP_W'(line_width_reg);
    always_comb
    begin
        priority if (lw_ext < CMP_W'(MIN_WIDTH))
            w_eff = CMP_W'(MIN_WIDTH);
        else if (lw_ext > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = lw_ext;
    end

    always_comb
    begin
        new_item.pixel     = pixel_in;
        new_item.fs        = frame_start;
        new_item.first_row = frame_start || first_row_reg;
        new_item.col       = frame_start ? '0 : col_reg;
        new_item.last      = (CMP_W'(new_item.col) + CMP_W'(1)) >= w_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                REG_LINE_WIDTH: line_width_reg <= cfg_data[LW_W-1:0];
                default:        threshold_reg  <= threshold_reg;
            endcase
        end
    end

    // column counter and first-row flag advance per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            first_row_reg <= 1'b1;
        end
        else if (accept)
        begin
            if (new_item.last)
            begin
                col_reg       <= '0;
                first_row_reg <= 1'b0;
            end
            else
            begin
                col_reg       <= new_item.col + 1'b1;
                first_row_reg <= new_item.first_row;
            end
        end
    end

    // a write to the column being read in the same cycle is caught here
    assign hit_a = wr.a_en && (wr.a_col == new_item.col);
    assign hit_b = wr.b_en && (wr.b_col == new_item.col);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= hit_a || hit_b;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= new_item;
            fwd_data_reg <= hit_a ? wr.a_data : wr.b_data;
        end
    end

    // line buffer, even columns in bank 0 and odd columns in bank 1
    assign bank_raddr = BANK_AW'(new_item.col >> 1);

    for (genvar b = 0; b < 2; b++)
    begin : g_bank
        always_comb
        begin
            priority if (wr.a_en && (wr.a_col[0] == 1'(b)))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = BANK_AW'(wr.a_col >> 1);
                bank_wdata[b] = wr.a_data;
            end
            else if (wr.b_en && (wr.b_col[0] == 1'(b)))
            begin
                bank_we[b]    = 1'b1;
                bank_waddr[b] = BANK_AW'(wr.b_col >> 1);
                bank_wdata[b] = wr.b_data;
            end
            else
            begin
                bank_we[b]    = 1'b0;
                bank_waddr[b] = BANK_AW'(wr.a_col >> 1);
                bank_wdata[b] = wr.a_data;
            end
        end

        edb_ram #(
            .WIDTH (SHARE_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (bank_waddr[b]),
            .wdata (bank_wdata[b]),
            .re    (accept),
            .raddr (bank_raddr),
            .rdata (bank_rdata[b])
        );
    end

    assign above = fwd_hit_reg ? fwd_data_reg
                 : share_t'(bank_rdata[s1_item_reg.col[0]]);

    edb_diffuse u_diffuse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (s1_item_reg),
        .above     (above),
        .threshold (threshold_reg),
        .result    (result),
        .wr        (wr)
    );

    // output register parts the diffusion stage from the consumer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= result;
            row_end_reg   <= s1_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign row_end   = row_end_reg;

endmodule

>>> rtl/edb_checker.sv
module edb_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [edb_pkg::PIX_W-1:0] out_value,
    input logic                      row_end
);
    import edb_pkg::*;

    logic [1:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // pixels accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(row_end))
        else $error("result beat changed while stalled");

    a_binary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_value == BLACK || out_value == WHITE))
        else $error("result pixel is neither black nor white");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result beat without an accepted pixel");

    a_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && pending_reg == 2'd2 |-> out_beat)
        else $error("pixel accepted with both stages full");

endmodule

bind error_diffusion_binarizer edb_checker u_edb_checker (.*);
